// ===== sv/edqt_pkg.sv =====
package edqt_pkg;

    localparam int LIMB_COUNT_DEF = 35;
    localparam int LIMB_W         = 64;
    localparam int FRAC_W         = 52;
    localparam int EXP_W          = 11;
    localparam int SIG_W          = FRAC_W + 1;
    localparam int WIDE_W         = SIG_W + LIMB_W;
    localparam int POS_W          = EXP_W - 6;
    localparam int FACTOR_W       = 4;
    localparam int OP_W           = 2;
    localparam int CODE_W         = 2;
    localparam int CFG_IDX_W      = 2;
    localparam int OUT_DATA_W     = 8;

    localparam logic [OP_W-1:0] OP_CLEAR     = 2'd0;
    localparam logic [OP_W-1:0] OP_ADD_TOTAL = 2'd1;
    localparam logic [OP_W-1:0] OP_ADD_TEST  = 2'd2;

    localparam logic [CODE_W-1:0] CMP_LESS    = 2'd0;
    localparam logic [CODE_W-1:0] CMP_EQUAL   = 2'd1;
    localparam logic [CODE_W-1:0] CMP_GREATER = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_NUMERATOR   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DENOMINATOR = 2'd1;

    localparam logic [FACTOR_W-1:0] NUMERATOR_RST   = 4'd3;
    localparam logic [FACTOR_W-1:0] DENOMINATOR_RST = 4'd4;

    typedef struct packed {
        logic start;
        logic clear;
        logic issue;
        logic load_out;
    } t_cmd;

endpackage

// ===== sv/exact_double_quantile_threshold_top.sv =====
// Exact quantile threshold test over binary64 weights.
// Input channel s_axis: tuser carries the opcode (clear both sums, add to
// total, add to cumulative and test), tdata the raw binary64 weight bits.
// Output channel m_axis: one item per input item, tdata bit 0 is
// threshold_reached, bits 2:1 the comparison code (less, equal, greater).
// Config channel i_cfg_*: index 0 numerator, index 1 denominator, 4 bits.
// Both sums are held in limb memories, one 64-bit limb per address.
// An add walks every limb through one adder with carry, and the scaling
// multiply and the compare follow as pipeline stages behind the read.
// An add or test reaches the output after the sweep over all limbs and the
// drain of the pipeline; a clear or an unused opcode goes straight to it.
// One item is worked at a time: the next item is taken once the result sits
// in the output register.
// Reset: both sums read as zero, numerator 3, denominator 4.
// A stalled receiver holds the output item; at most one more item is
// taken and finished, then the block waits for the output to drain.
module exact_double_quantile_threshold_top #(
    parameter int LIMB_COUNT = edqt_pkg::LIMB_COUNT_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    output logic                                s_axis_tready,
    input  logic [edqt_pkg::LIMB_W-1:0]         s_axis_tdata,   // [63:0] weight_bits
    input  logic [edqt_pkg::OP_W-1:0]           s_axis_tuser,   // [1:0] opcode
    output logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    output logic [edqt_pkg::OUT_DATA_W-1:0]     m_axis_tdata,   // [0] reached, [2:1] code
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [edqt_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [edqt_pkg::FACTOR_W-1:0]       i_cfg_data
);

    localparam int IDX_W = $clog2(LIMB_COUNT);

    edqt_pkg::t_cmd                cmd;
    logic [IDX_W-1:0]              idx;
    logic                          reached;
    logic [edqt_pkg::CODE_W-1:0]   code;

    assign o_cfg_ready  = 1'b1;
    assign m_axis_tdata = {{(edqt_pkg::OUT_DATA_W - edqt_pkg::CODE_W - 1){1'b0}},
                           code, reached};

    edqt_ctrl #(
        .LIMB_COUNT (LIMB_COUNT),
        .IDX_W      (IDX_W)
    ) u_ctrl (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .i_opcode      (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .o_cmd         (cmd),
        .o_idx         (idx)
    );

    edqt_dp #(
        .LIMB_COUNT (LIMB_COUNT),
        .IDX_W      (IDX_W)
    ) u_dp (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cmd               (cmd),
        .i_idx               (idx),
        .i_opcode            (s_axis_tuser),
        .i_weight_bits       (s_axis_tdata),
        .i_cfg_we            (i_cfg_valid && o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .o_threshold_reached (reached),
        .o_comparison_code   (code)
    );

endmodule

// ===== sv/edqt_ctrl.sv =====
module edqt_ctrl #(
    parameter int LIMB_COUNT = edqt_pkg::LIMB_COUNT_DEF,
    parameter int IDX_W      = $clog2(LIMB_COUNT)
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      s_axis_tvalid,
    output logic                      s_axis_tready,
    input  logic [edqt_pkg::OP_W-1:0] i_opcode,
    output logic                      m_axis_tvalid,
    input  logic                      m_axis_tready,
    output edqt_pkg::t_cmd            o_cmd,
    output logic [IDX_W-1:0]          o_idx
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SWEEP = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    localparam logic [IDX_W-1:0] LAST_LIMB  = IDX_W'(LIMB_COUNT - 1);
    localparam logic [IDX_W-1:0] DRAIN_LAST = IDX_W'(2);

    logic [1:0]       r_state, n_state;
    logic [IDX_W-1:0] r_cnt, n_cnt;
    logic             r_out_valid, n_out_valid;
    logic             accept;

    assign s_axis_tready = (r_state == ST_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign o_idx         = r_cnt;

    always_comb begin
        n_state  = r_state;
        n_cnt    = r_cnt;
        o_cmd    = '0;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    o_cmd.start = 1'b1;
                    o_cmd.clear = (i_opcode == edqt_pkg::OP_CLEAR);
                    n_cnt       = '0;
                    if (i_opcode == edqt_pkg::OP_ADD_TOTAL ||
                        i_opcode == edqt_pkg::OP_ADD_TEST) begin
                        n_state = ST_SWEEP;
                    end else begin
                        n_state = ST_DONE;
                    end
                end
            end
            ST_SWEEP: begin
                o_cmd.issue = 1'b1;
                if (r_cnt == LAST_LIMB) begin
                    n_cnt   = '0;
                    n_state = ST_DRAIN;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DRAIN: begin
                if (r_cnt == DRAIN_LAST) begin
                    n_state = ST_DONE;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_DONE: begin
                if (!r_out_valid || m_axis_tready) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_out_valid = r_out_valid;
        if (o_cmd.load_out) begin
            n_out_valid = 1'b1;
        end else if (m_axis_tready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

// ===== sv/edqt_dp.sv =====
module edqt_dp #(
    parameter int LIMB_COUNT = edqt_pkg::LIMB_COUNT_DEF,
    parameter int IDX_W      = $clog2(LIMB_COUNT)
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  edqt_pkg::t_cmd                     i_cmd,
    input  logic [IDX_W-1:0]                   i_idx,
    input  logic [edqt_pkg::OP_W-1:0]          i_opcode,
    input  logic [edqt_pkg::LIMB_W-1:0]        i_weight_bits,
    input  logic                               i_cfg_we,
    input  logic [edqt_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [edqt_pkg::FACTOR_W-1:0]      i_cfg_data,
    output logic                               o_threshold_reached,
    output logic [edqt_pkg::CODE_W-1:0]        o_comparison_code
);

    localparam int LW = edqt_pkg::LIMB_W;
    localparam int FW = edqt_pkg::FACTOR_W;
    localparam int PW = LW + FW;

    logic [LW-1:0] r_tot_mem [LIMB_COUNT];
    logic [LW-1:0] r_cum_mem [LIMB_COUNT];
    logic [LIMB_COUNT-1:0] r_tot_vld, r_cum_vld;

    logic [FW-1:0] r_num, r_den;

    logic [edqt_pkg::OP_W-1:0]   r_op;
    logic [LW-1:0]               r_lo;
    logic [edqt_pkg::SIG_W-1:0]  r_hi;
    logic [edqt_pkg::POS_W-1:0]  r_pos;

    logic [LW-1:0]    r_tot_rd, r_cum_rd;
    logic             r_tot_rv, r_cum_rv;
    logic             r_vb, r_vc, r_vd;
    logic [IDX_W-1:0] r_idx_b;
    logic             r_add_c;
    logic [LW-1:0]    r_tot_l, r_cum_l;
    logic [FW-1:0]    r_cc, r_ct;
    logic [LW-1:0]    r_lhs, r_rhs;
    logic [edqt_pkg::CODE_W-1:0] r_cmp;
    logic [edqt_pkg::CODE_W-1:0] r_code;

    logic [edqt_pkg::EXP_W-1:0]  expo;
    logic [edqt_pkg::SIG_W-1:0]  sig;
    logic [edqt_pkg::EXP_W-1:0]  shift;
    logic [edqt_pkg::WIDE_W-1:0] wide;

    logic [IDX_W-1:0] pos_ext, pos_next;
    logic [LW-1:0]    addend, tot_old, cum_old, add_src;
    logic [LW:0]      add_sum;
    logic             to_total;
    logic [LW-1:0]    tot_new, cum_new;
    logic [PW-1:0]    lhs_full, rhs_full;

    assign expo  = i_weight_bits[edqt_pkg::FRAC_W +: edqt_pkg::EXP_W];
    assign sig   = {(expo != '0), i_weight_bits[edqt_pkg::FRAC_W-1:0]};
    assign shift = (expo == '0) ? '0 : expo - 1'b1;
    assign wide  = {{LW{1'b0}}, sig} << shift[5:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num <= edqt_pkg::NUMERATOR_RST;
            r_den <= edqt_pkg::DENOMINATOR_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                edqt_pkg::REG_NUMERATOR:   r_num <= i_cfg_data;
                edqt_pkg::REG_DENOMINATOR: r_den <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_op  <= i_opcode;
            r_lo  <= wide[LW-1:0];
            r_hi  <= wide[edqt_pkg::WIDE_W-1:LW];
            r_pos <= shift[edqt_pkg::EXP_W-1:6];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.issue) begin
            r_tot_rd <= r_tot_mem[i_idx];
            r_cum_rd <= r_cum_mem[i_idx];
            r_tot_rv <= r_tot_vld[i_idx];
            r_cum_rv <= r_cum_vld[i_idx];
            r_idx_b  <= i_idx;
        end
    end

    assign pos_ext  = IDX_W'(r_pos);
    assign pos_next = pos_ext + 1'b1;
    assign tot_old  = r_tot_rv ? r_tot_rd : '0;
    assign cum_old  = r_cum_rv ? r_cum_rd : '0;
    assign to_total = (r_op == edqt_pkg::OP_ADD_TOTAL);
    assign add_src  = to_total ? tot_old : cum_old;

    always_comb begin
        if (r_idx_b == pos_ext) begin
            addend = r_lo;
        end else if (r_idx_b == pos_next) begin
            addend = LW'(r_hi);
        end else begin
            addend = '0;
        end
    end

    assign add_sum = {1'b0, add_src} + {1'b0, addend} + (LW+1)'(r_add_c);
    assign tot_new = to_total ? add_sum[LW-1:0] : tot_old;
    assign cum_new = to_total ? cum_old : add_sum[LW-1:0];

    always_ff @(posedge i_clk) begin
        if (r_vb) begin
            if (to_total) begin
                r_tot_mem[r_idx_b] <= add_sum[LW-1:0];
            end else begin
                r_cum_mem[r_idx_b] <= add_sum[LW-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tot_vld <= '0;
            r_cum_vld <= '0;
        end else if (i_cmd.clear) begin
            r_tot_vld <= '0;
            r_cum_vld <= '0;
        end else if (r_vb) begin
            if (to_total) begin
                r_tot_vld[r_idx_b] <= 1'b1;
            end else begin
                r_cum_vld[r_idx_b] <= 1'b1;
            end
        end
    end

    assign lhs_full = PW'(r_cum_l) * PW'(r_den) + PW'(r_cc);
    assign rhs_full = PW'(r_tot_l) * PW'(r_num) + PW'(r_ct);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_vc <= 1'b0;
            r_vd <= 1'b0;
        end else begin
            r_vb <= i_cmd.issue;
            r_vc <= r_vb;
            r_vd <= r_vc;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.start) begin
            r_add_c <= 1'b0;
            r_cc    <= '0;
            r_ct    <= '0;
            r_cmp   <= edqt_pkg::CMP_EQUAL;
        end else begin
            if (r_vb) begin
                r_add_c <= add_sum[LW];
                r_tot_l <= tot_new;
                r_cum_l <= cum_new;
            end
            if (r_vc) begin
                r_lhs <= lhs_full[LW-1:0];
                r_rhs <= rhs_full[LW-1:0];
                r_cc  <= lhs_full[PW-1:LW];
                r_ct  <= rhs_full[PW-1:LW];
            end
            if (r_vd && (r_lhs != r_rhs)) begin
                r_cmp <= (r_lhs < r_rhs) ? edqt_pkg::CMP_LESS : edqt_pkg::CMP_GREATER;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_code <= (r_op == edqt_pkg::OP_ADD_TEST) ? r_cmp : edqt_pkg::CMP_LESS;
        end
    end

    assign o_comparison_code   = r_code;
    assign o_threshold_reached = (r_code != edqt_pkg::CMP_LESS);

endmodule

// ===== sv/edqt_checker.sv =====
module edqt_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                s_axis_tvalid,
    input  logic                                s_axis_tready,
    input  logic                                m_axis_tvalid,
    input  logic                                m_axis_tready,
    input  logic [edqt_pkg::OUT_DATA_W-1:0]     m_axis_tdata
);

    ap_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tready) |=> (m_axis_tvalid && $stable(m_axis_tdata)))
        else $error("output item dropped or changed under stall");

    ap_reached_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[0] == (m_axis_tdata[2:1] != edqt_pkg::CMP_LESS)))
        else $error("threshold flag disagrees with comparison code");

    ap_code_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (m_axis_tdata[2:1] != 2'd3))
        else $error("comparison code out of range");

    ap_one_at_a_time: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
        else $error("input item taken while another is in progress");

endmodule

bind exact_double_quantile_threshold_top edqt_checker u_edqt_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

// ===== dv/tb_exact_double_quantile_threshold_top.sv =====
`timescale 1ns / 1ps

module tb_exact_double_quantile_threshold_top;

    localparam int LIMB_W         = edqt_pkg::LIMB_W;
    localparam int OP_W           = edqt_pkg::OP_W;
    localparam int CODE_W         = edqt_pkg::CODE_W;
    localparam int OUT_DATA_W     = edqt_pkg::OUT_DATA_W;
    localparam int CFG_IDX_W      = edqt_pkg::CFG_IDX_W;
    localparam int FACTOR_W       = edqt_pkg::FACTOR_W;
    localparam int EXP_W          = edqt_pkg::EXP_W;
    localparam int SIG_W          = edqt_pkg::SIG_W;
    localparam int FRAC_W         = edqt_pkg::FRAC_W;

    localparam int ACC_W          = edqt_pkg::LIMB_COUNT_DEF * LIMB_W;
    localparam int RX_HOLD_CYCLES = 1500;
    localparam int WATCHDOG_LIMIT = 10000;
    localparam int DRAIN_CYCLES   = 60;
    localparam int RANDOM_ITEMS   = 600;

    localparam logic [OP_W-1:0]      OP_UNUSED   = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef logic [ACC_W-1:0] t_acc;

    typedef struct packed {
        logic              reached;
        logic [CODE_W-1:0] code;
    } t_verdict;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [LIMB_W-1:0]     s_axis_tdata = '0;
    logic [OP_W-1:0]       s_axis_tuser = '0;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0] m_axis_tdata;
    logic                  i_cfg_valid = 1'b0;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [FACTOR_W-1:0]   i_cfg_data = '0;

    t_acc                  total_acc = '0;
    t_acc                  running_acc = '0;
    logic [FACTOR_W-1:0]   numerator_q = edqt_pkg::NUMERATOR_RST;
    logic [FACTOR_W-1:0]   denominator_q = edqt_pkg::DENOMINATOR_RST;

    t_verdict              verdict_q[$];
    int                    mismatch_count = 0;
    int                    items_sent = 0;
    int                    stall_requests = 0;
    logic                  no_idle = 1'b0;

    exact_double_quantile_threshold_top dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    function automatic t_acc weight_value(input logic [LIMB_W-1:0] bits);
        logic [EXP_W-1:0] expo;
        logic [SIG_W-1:0] sig;
        int               shift;
        expo  = bits[62:52];
        sig   = {(expo != '0), bits[FRAC_W-1:0]};
        shift = (expo == '0) ? 0 : int'(expo) - 1;
        return t_acc'(sig) << shift;
    endfunction

    function automatic t_verdict apply_weight_item(input logic [OP_W-1:0] op,
                                                   input logic [LIMB_W-1:0] bits);
        t_verdict v;
        t_acc     lhs;
        t_acc     rhs;
        v = '0;
        case (op)
            edqt_pkg::OP_CLEAR: begin
                total_acc   = '0;
                running_acc = '0;
            end
            edqt_pkg::OP_ADD_TOTAL: begin
                total_acc = total_acc + weight_value(bits);
            end
            edqt_pkg::OP_ADD_TEST: begin
                running_acc = running_acc + weight_value(bits);
                lhs = running_acc * t_acc'(denominator_q);
                rhs = total_acc * t_acc'(numerator_q);
                if (lhs < rhs) begin
                    v.code = edqt_pkg::CMP_LESS;
                end else if (lhs == rhs) begin
                    v.code = edqt_pkg::CMP_EQUAL;
                end else begin
                    v.code = edqt_pkg::CMP_GREATER;
                end
                v.reached = (v.code != edqt_pkg::CMP_LESS);
            end
            default: ;
        endcase
        return v;
    endfunction

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [LIMB_W-1:0] random_bits();
        return {$urandom, $urandom};
    endfunction

    function automatic logic [LIMB_W-1:0] pick_weight();
        logic [LIMB_W-1:0] w;
        w = random_bits();
        case ($urandom_range(0, 9))
            0, 1: ;
            2: w[62:52] = 11'h000;
            3: w[62:52] = 11'h7ff;
            4: w[62:52] = ($urandom_range(0, 1) != 0) ? 11'h001 : 11'h7fe;
            default: w[62:52] = 11'($urandom_range(960, 1090));
        endcase
        return w;
    endfunction

    function automatic logic [LIMB_W-1:0] vary_weight(input logic [LIMB_W-1:0] base);
        logic [LIMB_W-1:0] w;
        int                r;
        w = base;
        r = $urandom_range(0, 9);
        if (r == 7) begin
            w[63] = ~w[63];
        end else if (r == 8) begin
            w = random_bits();
        end else if (r == 9 && base[62:52] > 11'h001 && base[62:52] != 11'h7ff) begin
            w[62:52] = base[62:52] - 11'd1;
        end
        return w;
    endfunction

    task automatic send_item(input logic [OP_W-1:0] op, input logic [LIMB_W-1:0] bits);
        int       gap;
        t_verdict want;
        gap = pick_gap();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= bits;
        s_axis_tuser  <= op;
        do @(posedge i_clk); while (!s_axis_tready);
        want = apply_weight_item(op, bits);
        verdict_q = {verdict_q, want};
        items_sent++;
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (verdict_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [FACTOR_W-1:0] val);
        wait_drained();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        case (idx)
            edqt_pkg::REG_NUMERATOR:   numerator_q = val;
            edqt_pkg::REG_DENOMINATOR: denominator_q = val;
            default: ;
        endcase
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic set_fraction(input logic [FACTOR_W-1:0] num,
                                input logic [FACTOR_W-1:0] den);
        write_reg(edqt_pkg::REG_NUMERATOR, num);
        write_reg(edqt_pkg::REG_DENOMINATOR, den);
    endtask

    // clear, load the total with variants of one weight, then walk the cumulative sum across it, random items mixed in
    task automatic run_quantile_frame();
        logic [LIMB_W-1:0] base;
        int                n_total;
        int                n_cum;
        int                k;
        send_item(edqt_pkg::OP_CLEAR, random_bits());
        base    = pick_weight();
        n_total = $urandom_range(1, 8);
        n_cum   = $urandom_range(1, 2 * n_total + 2);
        for (k = 0; k < n_total + n_cum; k++) begin
            if ($urandom_range(0, 99) < 8) begin
                send_item(OP_W'($urandom_range(0, 3)), random_bits());
            end
            send_item((k < n_total) ? edqt_pkg::OP_ADD_TOTAL : edqt_pkg::OP_ADD_TEST,
                      vary_weight(base));
        end
    endtask

    task automatic test_reset_fraction();
        send_item(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(edqt_pkg::OP_ADD_TEST, 64'h0000_0000_0000_0000);
        repeat (4) send_item(edqt_pkg::OP_ADD_TOTAL, 64'h3FF0_0000_0000_0000);
        repeat (3) send_item(edqt_pkg::OP_ADD_TEST, 64'h3FF0_0000_0000_0000);
        send_item(edqt_pkg::OP_ADD_TEST, 64'hBFF0_0000_0000_0000);
        send_item(edqt_pkg::OP_CLEAR, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(edqt_pkg::OP_ADD_TOTAL, 64'hFFFF_FFFF_FFFF_FFFF);
        send_item(edqt_pkg::OP_ADD_TOTAL, 64'h7FF0_0000_0000_0000);
        send_item(edqt_pkg::OP_ADD_TEST, 64'h7FEF_FFFF_FFFF_FFFF);
        send_item(edqt_pkg::OP_ADD_TEST, 64'h000F_FFFF_FFFF_FFFF);
        send_item(edqt_pkg::OP_ADD_TEST, 64'h0000_0000_0000_0001);
        send_item(edqt_pkg::OP_ADD_TEST, 64'h0010_0000_0000_0000);
        send_item(OP_UNUSED, 64'h0000_0000_0000_0000);
        send_item(edqt_pkg::OP_ADD_TEST, 64'h7FFF_FFFF_FFFF_FFFF);
        send_item(edqt_pkg::OP_ADD_TEST, 64'h8000_0000_0000_0000);
        send_item(edqt_pkg::OP_CLEAR, 64'h0000_0000_0000_0000);
        send_item(edqt_pkg::OP_ADD_TEST, 64'h0000_0000_0000_0000);
    endtask

    task automatic test_fraction_sweep();
        logic [FACTOR_W-1:0] num_set[9];
        logic [FACTOR_W-1:0] den_set[9];
        int                  s;
        num_set = '{4'd1, 4'd15, 4'd15, 4'd1, 4'd0, 4'd9, 4'd0, 4'd10, 4'd3};
        den_set = '{4'd1, 4'd15, 4'd1, 4'd15, 4'd7, 4'd0, 4'd0, 4'd9, 4'd4};
        for (s = 0; s < 9; s++) begin
            set_fraction(num_set[s], den_set[s]);
            write_reg(REG_SPARE_A, FACTOR_W'($urandom));
            write_reg(REG_SPARE_B, FACTOR_W'($urandom));
            repeat (2) run_quantile_frame();
        end
    endtask

    task automatic test_output_stall();
        int k;
        wait_drained();
        stall_requests <= stall_requests + 1;
        no_idle = 1'b1;
        for (k = 0; k < 8; k++) begin
            send_item(edqt_pkg::OP_ADD_TOTAL + OP_W'(k % 2), pick_weight());
        end
        no_idle = 1'b0;
    endtask

    task automatic test_back_to_back();
        no_idle = 1'b1;
        repeat (4) run_quantile_frame();
        no_idle = 1'b0;
    endtask

    task automatic test_random_frames();
        int target;
        int frames;
        target = items_sent + RANDOM_ITEMS;
        frames = 0;
        while (items_sent < target) begin
            if (frames % 8 == 7) begin
                if ($urandom_range(0, 3) == 0) begin
                    write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_B : REG_SPARE_A,
                              FACTOR_W'($urandom));
                end
                set_fraction(FACTOR_W'($urandom), FACTOR_W'($urandom));
            end
            run_quantile_frame();
            frames++;
        end
    endtask

    initial begin : rx_drive
        int hold;
        int stalls_served;
        stalls_served = 0;
        forever begin
            @(posedge i_clk);
            if (stall_requests != stalls_served) begin
                stalls_served++;
                m_axis_tready <= 1'b0;
                hold = RX_HOLD_CYCLES;
            end else if (no_idle || $urandom_range(0, 3) != 0) begin
                m_axis_tready <= 1'b1;
                hold = 0;
            end else begin
                m_axis_tready <= 1'b0;
                hold = pick_gap();
            end
            repeat (hold) @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin : result_check
        t_verdict want;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (verdict_q.size() == 0) begin
                $error("result item with no expectation: tdata %0h", m_axis_tdata);
                mismatch_count++;
            end else begin
                want = verdict_q.pop_front();
                if (m_axis_tdata[0] !== want.reached) begin
                    $error("threshold_reached: expected %0d, actual %0d",
                           want.reached, m_axis_tdata[0]);
                    mismatch_count++;
                end
                if (m_axis_tdata[2:1] !== want.code) begin
                    $error("comparison_code: expected %0d, actual %0d",
                           want.code, m_axis_tdata[2:1]);
                    mismatch_count++;
                end
                if (m_axis_tdata[OUT_DATA_W-1:3] !== '0) begin
                    $error("tdata padding: expected 0, actual %0h",
                           m_axis_tdata[OUT_DATA_W-1:3]);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
                (i_cfg_valid && o_cfg_ready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("Mismatches found");
                $finish;
            end
        end
    end

    initial begin : main_sequence
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_reset_fraction();
        test_fraction_sweep();
        test_output_stall();
        test_back_to_back();
        test_random_frames();
        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0 && verdict_q.size() == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/edqt_pkg.sv
sv/edqt_ctrl.sv
sv/edqt_dp.sv
sv/exact_double_quantile_threshold_top.sv
sv/edqt_checker.sv
dv/tb_exact_double_quantile_threshold_top.sv
